@@ rtl/srtk_pkg.sv @@
// Package for the sigmoid top-k router: widths, register indexes, sigmoid table.
// Used by every module of the block but the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package srtk_pkg;
	localparam int MaxExperts = 256;
	localparam int MaxTopk = 8;
	localparam int CntW = $clog2(MaxExperts + 1);
	localparam int SlotW = $clog2(MaxTopk);
	localparam int FillW = $clog2(MaxTopk + 1);
	localparam int SumW = 16 + FillW;
	localparam int QDepth = 2;

	localparam logic [1:0] RegTopK = 2'd0;
	localparam logic [1:0] RegNormalize = 2'd1;
	localparam logic [1:0] RegWeightScale = 2'd2;

	typedef struct packed {
		logic [15:0] score;
		logic signed [18:0] choice;
		logic last;
		logic ranked;
	} item_t;

	typedef struct packed {
		logic [7:0] id;
		logic signed [18:0] choice;
		logic [15:0] score;
	} entry_t;

	function automatic logic [16:0] sig_tab(input logic [5:0] i);
		logic [16:0] t;
		case (i)
			6'd0: t = 17'd32768;  6'd1: t = 17'd36843;  6'd2: t = 17'd40793;
			6'd3: t = 17'd44511;  6'd4: t = 17'd47911;  6'd5: t = 17'd50941;
			6'd6: t = 17'd53581;  6'd7: t = 17'd55834;  6'd8: t = 17'd57724;
			6'd9: t = 17'd59287;  6'd10: t = 17'd60565; 6'd11: t = 17'd61598;
			6'd12: t = 17'd62428; 6'd13: t = 17'd63090; 6'd14: t = 17'd63615;
			6'd15: t = 17'd64030; 6'd16: t = 17'd64357; 6'd17: t = 17'd64614;
			6'd18: t = 17'd64816; 6'd19: t = 17'd64974; 6'd20: t = 17'd65097;
			6'd21: t = 17'd65194; 6'd22: t = 17'd65269; 6'd23: t = 17'd65328;
			6'd24: t = 17'd65374; 6'd25: t = 17'd65410; 6'd26: t = 17'd65438;
			6'd27: t = 17'd65459; 6'd28: t = 17'd65476; 6'd29: t = 17'd65489;
			6'd30: t = 17'd65500; 6'd31: t = 17'd65508; default: t = 17'd65514;
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

@@ rtl/srtk_if.sv @@
// Handshake channel interfaces for the router: input, result and config write.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface srtk_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] logit;
	logic signed [17:0] bias;
	logic last_expert;
	modport source (output valid, logit, bias, last_expert, input ready);
	modport sink (input valid, logit, bias, last_expert, output ready);
endinterface

interface srtk_out_if;
	logic valid;
	logic ready;
	logic [7:0] expert_id;
	logic [19:0] weight;
	logic [2:0] rank;
	logic last_result;
	modport source (output valid, expert_id, weight, rank, last_result, input ready);
	modport sink (input valid, expert_id, weight, rank, last_result, output ready);
endinterface

interface srtk_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/srtk_front.sv @@
// Front end: accepts an expert beat, forms its sigmoid score and choice value.
// Depends on srtk_pkg and srtk_if.
`timescale 1ns / 1ps
`default_nettype none
module srtk_front import srtk_pkg::*; (
	input wire clk,
	input wire arst_n,
	srtk_in_if.sink in_ch,
	output item_t item,
	output logic item_valid,
	input wire item_ready
);
	logic [CntW-1:0] count_q;
	logic [15:0] mag_s1;
	logic neg_s1, last_s1, ranked_s1, v_s1;
	logic signed [17:0] bias_s1;
	logic [16:0] mag;
	logic [5:0] idx;
	logic [16:0] t0, t1, s;
	logic [26:0] prod;
	logic [16:0] score;

	assign in_ch.ready = !v_s1 || item_ready;
	assign mag = in_ch.logit[15] ? 17'(-{in_ch.logit[15], in_ch.logit}) : {1'b0, in_ch.logit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			count_q <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				v_s1 <= 1'b1;
				if (in_ch.last_expert) count_q <= '0;
				else if (count_q < CntW'(MaxExperts)) count_q <= count_q + 1'b1;
			end else if (item_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mag_s1 <= mag[15:0] | {mag[16], 15'd0};
			neg_s1 <= in_ch.logit[15];
			bias_s1 <= in_ch.bias;
			last_s1 <= in_ch.last_expert;
			ranked_s1 <= count_q < CntW'(MaxExperts);
		end
	end

	// A magnitude of 32768 only comes from the most negative logit and maps to index 32.
	always_comb begin
		idx = neg_s1 && mag_s1 == 16'h8000 ? 6'd32 : {1'b0, mag_s1[14:10]};
		t0 = sig_tab(idx);
		t1 = sig_tab(idx == 6'd32 ? 6'd32 : idx + 6'd1);
		prod = 27'(t1 - t0) * 27'(mag_s1[9:0]) + 27'd512;
		s = idx == 6'd32 ? t0 : t0 + 17'(prod >> 10);
		score = neg_s1 ? 17'd65536 - s : s;
		item.score = score[15:0];
		item.choice = 19'(signed'({2'b00, score})) + 19'(bias_s1);
		item.last = last_s1;
		item.ranked = ranked_s1;
	end
	assign item_valid = v_s1;
endmodule
`default_nettype wire

@@ rtl/srtk_queue.sv @@
// Short FIFO between the front end and the back end.
// Depends on srtk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srtk_queue import srtk_pkg::*; (
	input wire clk,
	input wire arst_n,
	input item_t wr_item,
	input wire wr_valid,
	output logic wr_ready,
	output item_t rd_item,
	output logic rd_valid,
	input wire rd_ready
);
	item_t mem_q [QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'(QDepth);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_item = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_item;
endmodule
`default_nettype wire

@@ rtl/srtk_div.sv @@
// Restoring divider: one quotient bit per cycle into a 32-bit quotient; the back end takes Q1.16 weights.
// Depends on srtk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srtk_div import srtk_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire [31:0] num,
	input wire [SumW-1:0] den,
	output logic busy,
	output logic [31:0] quo
);
	logic [31:0] n_q;
	logic [SumW:0] r_q;
	logic [5:0] step_q;
	logic [SumW:0] trial;

	assign trial = {r_q[SumW-1:0], n_q[31]};
	assign busy = step_q != 6'd0;
	assign quo = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= '0;
		else if (start) step_q <= 6'd32;
		else if (busy) step_q <= step_q - 6'd1;
	end
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
		end else if (busy) begin
			if (trial >= {1'b0, den}) begin
				r_q <= trial - {1'b0, den};
				n_q <= {n_q[30:0], 1'b1};
			end else begin
				r_q <= trial;
				n_q <= {n_q[30:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/srtk_back.sv @@
// Back end: sorted top-k list insertion and result emission with weighting.
// Depends on srtk_pkg, srtk_if and srtk_div.
`timescale 1ns / 1ps
`default_nettype none
module srtk_back import srtk_pkg::*; (
	input wire clk,
	input wire arst_n,
	input item_t item,
	input wire item_valid,
	output logic item_ready,
	input wire [3:0] top_k,
	input wire normalize,
	input wire [15:0] weight_scale,
	srtk_out_if.source out_ch
);
	typedef enum logic [4:0] {
		StIns = 5'b00001, StSum = 5'b00010, StDiv = 5'b00100,
		StMul = 5'b01000, StOut = 5'b10000
	} state_t;

	state_t state_q;
	entry_t list_q [MaxTopk];
	logic [FillW-1:0] fill_q, n_q;
	logic [7:0] id_q;
	logic [SlotW-1:0] j_q;
	logic [SumW-1:0] sum_q;
	logic [32:0] prod_q;
	logic div_go_q;
	logic [3:0] k;
	logic [FillW-1:0] fill_nx;
	logic [FillW-1:0] n;
	logic [MaxTopk-1:0] below;
	logic div_start, div_busy;
	logic [31:0] quo;
	logic [19:0] wsat;
	logic [32:0] rnd;

	assign item_ready = state_q == StIns;

	// Slot p moves down when the new choice beats it; ties keep the earlier expert.
	always_comb begin
		for (int p = 0; p < MaxTopk; p++)
			below[p] = FillW'(p) < fill_q && list_q[p].choice >= item.choice;
		k = top_k == 4'd0 ? 4'd1 : (top_k > 4'(MaxTopk) ? 4'(MaxTopk) : top_k);
		// The count of results must include the beat being inserted this cycle.
		fill_nx = (state_q == StIns && item_valid && item.ranked && fill_q < FillW'(MaxTopk)) ?
			fill_q + 1'b1 : fill_q;
		n = FillW'(k) < fill_nx ? FillW'(k) : fill_nx;
	end

	always_ff @(posedge clk) begin
		if (state_q == StIns && item_valid && item.ranked) begin
			for (int p = MaxTopk - 1; p >= 0; p--) begin
				if (!below[p]) begin
					if (p == 0 || below[p-1])
						list_q[p] <= '{id: id_q, choice: item.choice, score: item.score};
					else
						list_q[p] <= list_q[p-1];
				end
			end
		end
	end

	// The divider starts in the first cycle of each divide step, once the sum is complete.
	assign div_start = div_go_q;
	srtk_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({list_q[j_q].score, 16'd0} + 32'(sum_q >> 1)),
		.den(sum_q),
		.busy(div_busy), .quo(quo)
	);

	assign rnd = prod_q + 33'd2048;
	assign wsat = |rnd[32:32] || |(rnd[31:12] >> 20) ? 20'hFFFFF : rnd[31:12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIns;
			fill_q <= '0;
			id_q <= '0;
			j_q <= '0;
			div_go_q <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			case (state_q)
				StIns: if (item_valid) begin
					if (item.ranked && fill_q < FillW'(MaxTopk)) fill_q <= fill_q + 1'b1;
					if (item.last) begin
						id_q <= '0;
						j_q <= '0;
						state_q <= StSum;
					end else if (item.ranked) begin
						id_q <= id_q + 8'd1;
					end
				end
				StSum: if (FillW'(j_q) + 1'b1 >= n_q) begin
					j_q <= '0;
					div_go_q <= normalize;
					state_q <= normalize ? StDiv : StMul;
				end else begin
					j_q <= j_q + 1'b1;
				end
				StDiv: begin
					div_go_q <= 1'b0;
					if (!div_busy && !div_go_q) state_q <= StMul;
				end
				StMul: state_q <= StOut;
				StOut: if (!out_ch.valid) begin
					out_ch.valid <= 1'b1;
				end else if (out_ch.ready) begin
					out_ch.valid <= 1'b0;
					if (out_ch.last_result) begin
						fill_q <= '0;
						state_q <= StIns;
					end else begin
						j_q <= j_q + 1'b1;
						div_go_q <= normalize;
						state_q <= normalize ? StDiv : StMul;
					end
				end
				default: state_q <= StIns;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StIns) begin
			n_q <= n;
			sum_q <= '0;
		end
		if (state_q == StSum) sum_q <= sum_q + SumW'(list_q[j_q].score);
		// A normalized weight can reach 1.0, which needs the seventeenth bit.
		if (state_q == StMul)
			prod_q <= 33'(normalize ? quo[16:0] : {1'b0, list_q[j_q].score}) *
				33'(weight_scale);
		if (state_q == StOut && !out_ch.valid) begin
			out_ch.expert_id <= list_q[j_q].id;
			out_ch.weight <= wsat;
			out_ch.rank <= 3'(j_q);
			out_ch.last_result <= FillW'(j_q) + 1'b1 == n_q;
		end
	end
endmodule
`default_nettype wire

@@ rtl/sigmoid_router_top_k_unit.sv @@
// Sigmoid top-k router. An expert beat reaches the sorted list through the front stage
// and queue; beats can be accepted every cycle within a token unless the back end is
// busy with results. After the last beat: a sum pass over the list, then per result a
// divide in the 32-step divider (with normalize), a multiply and an output step.
// Reset (arst_n low) clears the counts and sets top_k=1, normalize=0, weight_scale=4096.
`timescale 1ns / 1ps
`default_nettype none
module sigmoid_router_top_k_unit import srtk_pkg::*; (
	input wire clk,
	input wire arst_n,
	srtk_in_if.sink in_ch,
	srtk_out_if.source out_ch,
	srtk_cfg_if.sink cfg
);
	logic [3:0] top_k_q;
	logic normalize_q;
	logic [15:0] weight_scale_q;
	item_t f_item, q_item;
	logic f_valid, f_ready, q_valid, q_ready;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q <= 4'd1;
			normalize_q <= 1'b0;
			weight_scale_q <= 16'd4096;
		end else if (cfg.valid) begin
			case (cfg.index)
				RegTopK: top_k_q <= cfg.data[3:0];
				RegNormalize: normalize_q <= cfg.data[0];
				RegWeightScale: weight_scale_q <= cfg.data;
				default: ;
			endcase
		end
	end

	srtk_front u_front (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.item(f_item), .item_valid(f_valid), .item_ready(f_ready));
	srtk_queue u_queue (.clk(clk), .arst_n(arst_n), .wr_item(f_item), .wr_valid(f_valid),
		.wr_ready(f_ready), .rd_item(q_item), .rd_valid(q_valid), .rd_ready(q_ready));
	srtk_back u_back (.clk(clk), .arst_n(arst_n), .item(q_item), .item_valid(q_valid),
		.item_ready(q_ready), .top_k(top_k_q), .normalize(normalize_q),
		.weight_scale(weight_scale_q), .out_ch(out_ch));
endmodule
`default_nettype wire

@@ rtl/srtk_checker.sv @@
// Port-level checker for the router, bound to the top level.
// Depends on sigmoid_router_top_k_unit, to which it is bound.
`timescale 1ns / 1ps
`default_nettype none
module srtk_checker (
	input wire clk,
	input wire arst_n,
	input wire out_valid,
	input wire out_ready,
	input wire [2:0] rank,
	input wire last_result
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rank)) else $error("result dropped");
	a_rank_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_result |=> !out_valid || rank != 3'd0)
		else $error("rank restarted");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid) else $error("back to back results");
endmodule

bind sigmoid_router_top_k_unit srtk_checker u_chk (.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .rank(out_ch.rank),
	.last_result(out_ch.last_result));
`default_nettype wire
